// ===== src/b64c_pkg.sv =====
// Shared types, character constants and alphabet functions for the Base64 codec.
`timescale 1ns / 1ps

package b64c_pkg;

  // Depth of the job queue between the gathering front end and the emitting back end.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_PAD     = 8'h3D;

  localparam logic [1:0] KIND_ALPHA = 2'd0;
  localparam logic [1:0] KIND_PAD   = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd2;

  // One finished group, ready to be turned into result items.
  typedef struct packed {
    logic        encode;  // group was gathered in encode mode
    logic [23:0] bits;    // group bits, left aligned
    logic [2:0]  n_out;   // number of results, 1 to 4
    logic [2:0]  n_chr;   // encode: results that are alphabet characters
    logic        err;     // decode: group held an invalid character
  } job_t;

  typedef struct packed {
    logic [5:0] sextet;
    logic [1:0] kind;
  } sextet_t;

  function automatic logic [7:0] sextet_to_ascii(input logic [5:0] s);
    logic [7:0] w;
    w = {2'b00, s};
    if (s < 6'd26)      return CHAR_UPPER_A + w;
    else if (s < 6'd52) return w + 8'd71;
    else if (s < 6'd62) return w - 8'd4;
    else if (s == 6'd62) return CHAR_PLUS;
    else                return CHAR_SLASH;
  endfunction

  function automatic sextet_t ascii_to_sextet(input logic [7:0] c);
    sextet_t r;
    r.kind   = KIND_ALPHA;
    r.sextet = 6'd0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r.sextet = 6'(c - CHAR_UPPER_A);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      r.sextet = 6'(c - 8'd71);
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      r.sextet = 6'(c + 8'd4);
    end else if (c == CHAR_PLUS) begin
      r.sextet = 6'd62;
    end else if (c == CHAR_SLASH) begin
      r.sextet = 6'd63;
    end else if (c == CHAR_PAD) begin
      r.kind = KIND_PAD;
    end else begin
      r.kind = KIND_BAD;
    end
    return r;
  endfunction

endpackage

// ===== src/b64c_front.sv =====
// Front end: mode register, group gathering and classification into jobs.
`timescale 1ns / 1ps

module b64c_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  input  logic          cfg_data,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          job_push,
  output b64c_pkg::job_t job
);
  import b64c_pkg::*;

  logic        encode_mode;
  logic [23:0] group_bits;
  logic [1:0]  group_count;
  logic [1:0]  pad_count;
  logic        group_error;

  logic [23:0] group_bits_next;
  logic [1:0]  group_count_next;
  logic [1:0]  pad_count_next;
  logic        group_error_next;

  logic [2:0]  have;
  logic        done;
  sextet_t     dec;
  logic [2:0]  pads_sum;
  logic [2:0]  pads_total;
  logic [1:0]  pads_sat;
  logic [1:0]  nbytes;

  assign have = {1'b0, group_count} + 3'd1;
  assign dec  = ascii_to_sextet(in_byte);

  always_comb begin
    group_bits_next  = group_bits;
    group_count_next = group_count;
    pad_count_next   = pad_count;
    group_error_next = group_error;
    job              = '0;
    job.encode       = encode_mode;
    job_push         = 1'b0;
    done             = 1'b0;
    pads_sum         = {1'b0, pad_count} + {2'b00, (dec.kind == KIND_PAD)};
    pads_total       = '0;
    pads_sat         = '0;
    nbytes           = '0;
    if (encode_mode) begin
      group_bits_next = {group_bits[15:0], in_byte};
      done            = (have == 3'd3) || in_last;
      job.n_out       = 3'd4;
      job.n_chr       = have + 3'd1;
      unique case (have)
        3'd1:    job.bits = {group_bits_next[7:0], 16'd0};
        3'd2:    job.bits = {group_bits_next[15:0], 8'd0};
        default: job.bits = group_bits_next;
      endcase
      job_push = accept && done;
    end else begin
      group_bits_next  = {group_bits[17:0], dec.sextet};
      group_error_next = group_error | (dec.kind == KIND_BAD);
      done             = (have == 3'd4) || in_last;
      pads_total       = pads_sum + (3'd4 - have);
      pads_sat         = (pads_total > 3'd3) ? 2'd3 : pads_total[1:0];
      nbytes           = 2'd3 - pads_sat;
      job.n_out        = {1'b0, nbytes};
      job.err          = group_error_next;
      unique case (have)
        3'd1:    job.bits = {group_bits_next[5:0], 18'd0};
        3'd2:    job.bits = {group_bits_next[11:0], 12'd0};
        3'd3:    job.bits = {group_bits_next[17:0], 6'd0};
        default: job.bits = group_bits_next;
      endcase
      // A group made wholly of padding yields no result and no job.
      job_push       = accept && done && (nbytes != 2'd0);
      pad_count_next = (pads_sum > 3'd3) ? 2'd3 : pads_sum[1:0];
    end
    group_count_next = have[1:0];
    if (done) begin
      group_bits_next  = '0;
      group_count_next = '0;
      pad_count_next   = '0;
      group_error_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      encode_mode <= 1'b1;
      group_bits  <= '0;
      group_count <= '0;
      pad_count   <= '0;
      group_error <= 1'b0;
    end else if (cfg_valid) begin
      encode_mode <= cfg_data;
      group_bits  <= '0;
      group_count <= '0;
      pad_count   <= '0;
      group_error <= 1'b0;
    end else if (accept) begin
      group_bits  <= group_bits_next;
      group_count <= group_count_next;
      pad_count   <= pad_count_next;
      group_error <= group_error_next;
    end
  end

endmodule

// ===== src/b64c_job_queue.sv =====
// Short queue of finished groups between the front end and the back end.
`timescale 1ns / 1ps

module b64c_job_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  b64c_pkg::job_t wr_job,
  output logic           full,
  input  logic           rd,
  output logic           avail,
  output b64c_pkg::job_t rd_job
);
  import b64c_pkg::*;

  job_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_wr;
  logic               do_rd;

  assign full   = (count == Q_CNT_W'(Q_DEPTH));
  assign avail  = (count != '0);
  assign rd_job = slots[rd_ptr];
  assign do_wr  = wr && !full;
  assign do_rd  = rd && avail;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/b64c_back.sv =====
// Back end: walks each job one result per cycle into the output register while it is empty or popped.
`timescale 1ns / 1ps

module b64c_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_avail,
  input  b64c_pkg::job_t job_in,
  output logic           job_take,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic           out_last,
  output logic           bad_char
);
  import b64c_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       out_valid;

  logic       adv;
  logic       fin;
  logic [7:0] res_byte;
  logic       res_last;
  logic [5:0] sextet;

  assign adv      = cur_valid && (!out_valid || pop);
  assign res_last = (({1'b0, idx} + 3'd1) == cur.n_out);
  assign fin      = adv && res_last;
  assign job_take = job_avail && (!cur_valid || fin);
  assign empty    = !out_valid;

  always_comb begin
    unique case (idx)
      2'd0:    sextet = cur.bits[23:18];
      2'd1:    sextet = cur.bits[17:12];
      2'd2:    sextet = cur.bits[11:6];
      default: sextet = cur.bits[5:0];
    endcase
    if (cur.encode) begin
      res_byte = ({1'b0, idx} < cur.n_chr) ? sextet_to_ascii(sextet) : CHAR_PAD;
    end else begin
      unique case (idx)
        2'd0:    res_byte = cur.bits[23:16];
        2'd1:    res_byte = cur.bits[15:8];
        default: res_byte = cur.bits[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte <= res_byte;
      out_last <= res_last;
      bad_char <= !cur.encode && cur.err;
    end
    if (job_take) begin
      cur <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (job_take) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (fin) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else if (adv) begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

// ===== src/base64_stream_codec.sv =====
// Top level of the Base64 stream codec: front end, job queue and back end.
`timescale 1ns / 1ps

// Base64 (standard alphabet, '=' padding) codec with queue-style ports. In encode mode
// every third byte, or a byte flagged last, completes a group that yields four
// characters; in decode mode every fourth character, or one flagged last, completes a
// group that yields up to three bytes, with a missing tail treated as padding and an
// invalid character flagged on every byte of its group. Items are taken one per cycle
// while the two-entry job queue has room; the back end emits one result per cycle
// while results are popped. Encoding is therefore paced by the result port, as each
// group of three bytes yields four characters, while decoding sustains one character
// per cycle, paced by the input port, as each group of four characters yields at most
// three bytes. A mode write, taken on any cycle, clears any partly gathered group.
module base64_stream_codec (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       bad_char
);
  import b64c_pkg::*;

  logic accept;
  logic job_push;
  job_t job_wr;
  logic job_avail;
  logic job_take;
  job_t job_rd;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  b64c_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .job_push  (job_push),
    .job       (job_wr)
  );

  b64c_job_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (job_push),
    .wr_job (job_wr),
    .full   (full),
    .rd     (job_take),
    .avail  (job_avail),
    .rd_job (job_rd)
  );

  b64c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_avail (job_avail),
    .job_in    (job_rd),
    .job_take  (job_take),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .bad_char  (bad_char)
  );

endmodule
